@@ rtl/multi_button_debounce_keypad_assert.svh @@
// Assertion macros used by the keypad debouncer top level.
`ifndef MULTI_BUTTON_DEBOUNCE_KEYPAD_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_KEYPAD_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MBDK_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad debouncer check failed");

// Next-cycle implication, checked outside reset.
`define MBDK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad debouncer check failed");

`endif

@@ rtl/mbdk_pkg.sv @@
// Types, constants and a helper function of the keypad debouncer.
package mbdk_pkg;

  localparam int BUTTONS    = 9;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = 4;
  localparam int DEBOUNCE_W = 16;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd80;
  localparam logic [BUTTONS-1:0]    ENABLE_RESET   = '1;

  localparam logic REG_DEBOUNCE = 1'b0;
  localparam logic REG_ENABLE   = 1'b1;

  typedef struct packed {
    logic [BUTTONS-1:0]   raw_levels;
    logic [TIME_BITS-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic               event_valid;
    logic [IDX_W-1:0]   event_button;
    logic               event_pressed;
    logic               key_active;
    logic [IDX_W-1:0]   key_button;
    logic [BUTTONS-1:0] pressed_mask;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [BUTTONS-1:0] changed;
    logic [BUTTONS-1:0] state;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  function automatic logic [IDX_W-1:0] lowest_idx(input logic [BUTTONS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = BUTTONS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/mbdk_front.sv @@
// Front end: accepts polls, applies the lockout test per button and queues the changes.
module mbdk_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mbdk_pkg::in_item_t                   in_data,
  input  logic [mbdk_pkg::DEBOUNCE_W-1:0]      lockout_ms,
  input  logic [mbdk_pkg::BUTTONS-1:0]         enable_mask,
  input  mbdk_pkg::q_stat_t                    q_stat,
  output logic                                 push,
  output mbdk_pkg::q_entry_t                   push_data
);
  import mbdk_pkg::*;

  logic [BUTTONS-1:0]   state_r;
  logic [BUTTONS-1:0]   state_nxt;
  logic [TIME_BITS-1:0] ctime_r [BUTTONS];
  logic [BUTTONS-1:0]   changed;
  logic [TIME_BITS-1:0] elapsed [BUTTONS];

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < BUTTONS; i++) begin
      elapsed[i] = in_data.now_ms - ctime_r[i];
      changed[i] = enable_mask[i] && (in_data.raw_levels[i] != state_r[i]) &&
                   (elapsed[i] > TIME_BITS'(lockout_ms));
    end
    state_nxt         = state_r ^ changed;
    push_data.changed = changed;
    push_data.state   = state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        ctime_r[i] <= '0;
      end
    end else if (push) begin
      state_r <= state_nxt;
      for (int i = 0; i < BUTTONS; i++) begin
        if (changed[i]) begin
          ctime_r[i] <= in_data.now_ms;
        end
      end
    end
  end

endmodule

@@ rtl/mbdk_queue.sv @@
// Short queue of classified polls between the front end and the back end.
module mbdk_queue #(
  parameter int QDEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbdk_pkg::q_entry_t push_data,
  input  logic               pop,
  output mbdk_pkg::q_entry_t pop_data,
  output mbdk_pkg::q_stat_t  q_stat
);
  import mbdk_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QDEPTH);

  q_entry_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == FULL_CNT);
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

endmodule

@@ rtl/mbdk_back.sv @@
// Back end: emits one event per changed button, then the status result, through an output register.
module mbdk_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mbdk_pkg::q_entry_t  pop_data,
  input  mbdk_pkg::q_stat_t   q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mbdk_pkg::out_item_t out_data
);
  import mbdk_pkg::*;

  back_state_t        state_r;
  back_state_t        state_nxt;
  logic [BUTTONS-1:0] pend_r;
  logic [BUTTONS-1:0] pend_nxt;
  logic [BUTTONS-1:0] mask_r;
  logic [BUTTONS-1:0] mask_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  out_item_t          out_data_r;
  out_item_t          out_data_nxt;
  logic               adv;
  logic [BUTTONS-1:0] low_bit;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign adv       = !out_valid_r || out_ready;
  assign low_bit   = pend_r & (~pend_r + BUTTONS'(1));

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    mask_nxt      = mask_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          pend_nxt  = pop_data.changed;
          mask_nxt  = pop_data.state;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          if (pend_r != '0) begin
            out_data_nxt.event_valid   = 1'b1;
            out_data_nxt.event_button  = lowest_idx(pend_r);
            out_data_nxt.event_pressed = |(low_bit & mask_r);
            pend_nxt                   = pend_r & ~low_bit;
          end else begin
            out_data_nxt.key_active   = |mask_r;
            out_data_nxt.key_button   = lowest_idx(mask_r);
            out_data_nxt.pressed_mask = mask_r;
            out_data_nxt.last         = 1'b1;
            state_nxt                 = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/multi_button_debounce_keypad.sv @@
// Results pass through the queue, the pend and mask registers and the output register; a poll
// with n accepted changes leaves as n + 1 results, one per cycle while out_ready is high,
// before the back end pops the next poll. The front end takes a poll every cycle while the
// queue of QDEPTH polls has room. Reset clears every button to released, every change time
// to zero, the lockout time to 80 and enable_mask to all ones; no clearing pass is needed.
module multi_button_debounce_keypad #(
  parameter int QDEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mbdk_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mbdk_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbdk_pkg::ADDR_W-1:0]     paddr,
  input  logic [mbdk_pkg::DATA_W-1:0]     pwdata,
  output logic [mbdk_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import mbdk_pkg::*;

  `include "multi_button_debounce_keypad_assert.svh"

  logic [DEBOUNCE_W-1:0] debounce_r;
  logic [BUTTONS-1:0]    enable_r;
  logic                  cfg_wr;
  logic                  push;
  logic                  pop;
  q_entry_t              push_data;
  q_entry_t              pop_data;
  q_stat_t               q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_DEBOUNCE: prdata = DATA_W'(debounce_r);
      REG_ENABLE:   prdata = DATA_W'(enable_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      enable_r   <= ENABLE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DEBOUNCE: debounce_r <= pwdata[DEBOUNCE_W-1:0];
        REG_ENABLE:   enable_r   <= pwdata[BUTTONS-1:0];
        default:      ;
      endcase
    end
  end

  mbdk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .lockout_ms  (debounce_r),
    .enable_mask (enable_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  mbdk_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  mbdk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_data  (pop_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `MBDK_ASSERT_NEXT(a_push_fills_queue, push, !q_stat.empty)
  `MBDK_ASSERT_IMPL(a_key_is_pressed, out_valid && out_data.last && out_data.key_active,
                    (out_data.pressed_mask & ~(out_data.pressed_mask - 9'd1)) ==
                    (9'd1 << out_data.key_button))
  `MBDK_ASSERT_IMPL(a_idle_keypad, out_valid && out_data.last && !out_data.key_active,
                    out_data.pressed_mask == '0 && out_data.key_button == '0)

endmodule

@@ tb/sv/multi_button_debounce_keypad_tb.sv @@
// Self-checking testbench for the keypad debouncer with a valid/ready driver and monitor.
`timescale 1ns / 1ps

module multi_button_debounce_keypad_tb;
  import mbdk_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 150;
  localparam int MAX_PRINTS     = 20;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [DATA_W-1:0]   pwdata    = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  in_item_t            poll_q[$];
  out_item_t           expected_q[$];

  logic [DEBOUNCE_W-1:0] lockout_ms;
  logic [BUTTONS-1:0]    enabled_btns;
  logic [BUTTONS-1:0]    pred_pressed;
  logic [TIME_BITS-1:0]  change_time[BUTTONS];

  logic [TIME_BITS-1:0]  poll_time   = '0;
  logic [BUTTONS-1:0]    held_levels = '0;

  logic in_fire      = 1'b0;
  logic calm         = 1'b0;
  int   send_gap     = 0;
  int   recv_gap     = 0;
  int   hold_left    = 0;
  int   hold_req_cnt = 0;
  int   hold_ack_cnt = 0;
  int   idle_cycles  = 0;
  int   mismatch_cnt = 0;

  multi_button_debounce_keypad dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    mismatch_cnt++;
  endtask

  task automatic predict_poll(input in_item_t poll);
    out_item_t            res;
    logic [TIME_BITS-1:0] elapsed;
    for (int b = 0; b < BUTTONS; b++) begin
      elapsed = poll.now_ms - change_time[b];
      if (enabled_btns[b] && poll.raw_levels[b] != pred_pressed[b] &&
          elapsed > TIME_BITS'(lockout_ms)) begin
        pred_pressed[b]    = poll.raw_levels[b];
        change_time[b]     = poll.now_ms;
        res                = '0;
        res.event_valid    = 1'b1;
        res.event_button   = IDX_W'(b);
        res.event_pressed  = poll.raw_levels[b];
        expected_q.push_back(res);
      end
    end
    res              = '0;
    res.last         = 1'b1;
    res.pressed_mask = pred_pressed;
    res.key_active   = |pred_pressed;
    for (int b = BUTTONS - 1; b >= 0; b--) begin
      if (pred_pressed[b]) begin
        res.key_button = IDX_W'(b);
      end
    end
    expected_q.push_back(res);
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result transaction with nothing expected");
    end else begin
      want = expected_q.pop_front();
      compare_field("event_valid", int'(got.event_valid), int'(want.event_valid));
      compare_field("event_button", int'(got.event_button), int'(want.event_button));
      compare_field("event_pressed", int'(got.event_pressed), int'(want.event_pressed));
      compare_field("key_active", int'(got.key_active), int'(want.key_active));
      compare_field("key_button", int'(got.key_button), int'(want.key_button));
      compare_field("pressed_mask", int'(got.pressed_mask), int'(want.pressed_mask));
      compare_field("last", int'(got.last), int'(want.last));
    end
  endtask

  always @(posedge clk) begin : monitor_proc
    in_fire <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_poll(in_data);
      end
      if (out_valid && out_ready) begin
        check_result(out_data);
      end
    end
  end

  always @(negedge clk) begin : driver_proc
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (poll_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
        send_gap <= $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (poll_q.size() > 0) begin
        in_data  <= poll_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver_proc
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_ack_cnt != hold_req_cnt) begin
      hold_ack_cnt <= hold_ack_cnt + 1;
      hold_left    <= LONG_HOLD - 1;
      out_ready    <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      recv_gap  <= $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog_proc
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_DEBOUNCE) begin
      lockout_ms = value[DEBOUNCE_W-1:0];
    end else begin
      enabled_btns = value[BUTTONS-1:0];
    end
  endtask

  task automatic add_poll(input logic [BUTTONS-1:0] raw, input logic [TIME_BITS-1:0] now);
    in_item_t item;
    item.raw_levels = raw;
    item.now_ms     = now;
    poll_q.push_back(item);
  endtask

  task automatic queue_polls(input int count);
    int unsigned        step;
    int unsigned        pick;
    logic [BUTTONS-1:0] noise;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_poll(BUTTONS'($urandom), $urandom);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          step = 0;
        end else if (pick == 1) begin
          step = $urandom;
        end else begin
          step = $urandom_range(0, int'(lockout_ms) + int'(lockout_ms) / 2 + 4);
        end
        poll_time = poll_time + step;
        if ($urandom_range(0, 3) == 0) begin
          held_levels = held_levels ^ BUTTONS'($urandom);
        end
        noise = ($urandom_range(0, 2) == 0) ? BUTTONS'($urandom & $urandom) : '0;
        add_poll(held_levels ^ noise, poll_time);
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (poll_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  initial begin : stimulus_proc
    logic [DEBOUNCE_W-1:0] lockout_pick;
    logic [BUTTONS-1:0]    enable_pick;
    lockout_ms   = DEBOUNCE_RESET;
    enabled_btns = ENABLE_RESET;
    pred_pressed = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      change_time[b] = '0;
    end
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    add_poll(9'h1FF, 32'd0);
    add_poll(9'h1FF, 32'd80);
    add_poll(9'h1FF, 32'd81);
    add_poll(9'h000, 32'd100);
    add_poll(9'h000, 32'd162);
    add_poll(9'h100, 32'd300);
    add_poll(9'h0A0, 32'd400);
    add_poll(9'h000, 32'hFFFF_FFF0);
    add_poll(9'h020, 32'h0000_0020);
    add_poll(9'h020, 32'h0000_0041);
    wait_idle();

    write_reg(REG_DEBOUNCE, 32'hABCD_0000);
    write_reg(REG_ENABLE, 32'hFFFF_FF55);
    add_poll(9'h1FF, 32'h0000_0041);
    add_poll(9'h000, 32'h0000_0041);
    add_poll(9'h0AA, 32'h0000_0042);
    add_poll(9'h000, 32'h0000_0043);
    wait_idle();

    write_reg(REG_DEBOUNCE, 32'h1234_FFFF);
    write_reg(REG_ENABLE, 32'h0000_FE00);
    add_poll(9'h1FF, 32'h0000_2000);
    add_poll(9'h0F0, 32'h0009_0000);
    wait_idle();

    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    add_poll(9'h1FF, 32'h0001_0040);
    add_poll(9'h1FF, 32'h0001_0043);
    add_poll(9'h000, 32'hFFFF_FFFF);
    add_poll(9'h1FF, 32'h0000_0000);
    wait_idle();

    poll_time = 32'hFFFF_F000;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       lockout_pick = '0;
        1:       lockout_pick = '1;
        7:       lockout_pick = DEBOUNCE_RESET;
        default: lockout_pick = DEBOUNCE_W'($urandom_range(1, 300));
      endcase
      case (ph)
        3:       enable_pick = '0;
        0, 7:    enable_pick = '1;
        default: enable_pick = ($urandom_range(0, 1) == 0) ? '1 : BUTTONS'($urandom);
      endcase
      write_reg(REG_DEBOUNCE, ($urandom & 32'hFFFF_0000) | DATA_W'(lockout_pick));
      write_reg(REG_ENABLE, ($urandom & 32'hFFFF_FE00) | DATA_W'(enable_pick));
      calm = (ph == 7);
      queue_polls(38);
      if (ph == 2 || ph == 5) begin
        hold_req_cnt = hold_req_cnt + 1;
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
